[hw/rtl/cpid_pkg.sv]
// ----------------------------------------------------------------------------
// cpid_pkg
// Shared types and constants for the cascaded PID controller.
// ----------------------------------------------------------------------------
package cpid_pkg;

    localparam int GAIN_W    = 20;
    localparam int PERIOD_W  = 16;
    localparam int INTEG_W   = 48;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 3;
    // magnitude operand of the shared multiplier, split into two partial products
    localparam int MAG_W     = 49;
    localparam int LO_W      = 24;
    localparam int HI_W      = MAG_W - LO_W;
    localparam int PROD_W    = GAIN_W + MAG_W;
    localparam int SUM_W     = 64;

    localparam logic [GAIN_W-1:0]   OUTER_KP_RST = 20'd32768;
    localparam logic [GAIN_W-1:0]   INNER_KP_RST = 20'd52429;
    localparam logic [PERIOD_W-1:0] PERIOD_RST   = 16'd66;
    localparam logic [PERIOD_W-1:0] INV_RST      = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OUTER_KP = 3'd0,
        REG_OUTER_KI = 3'd1,
        REG_OUTER_KD = 3'd2,
        REG_INNER_KP = 3'd3,
        REG_INNER_KI = 3'd4,
        REG_INNER_KD = 3'd5,
        REG_PERIOD   = 3'd6,
        REG_INV      = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ERR,
        S_DIFF,
        S_MLO,
        S_MHI,
        S_POST,
        S_OUT,
        S_PUSH
    } t_state;

    typedef enum logic [2:0] {
        TERM_STEP,
        TERM_DERIV,
        TERM_P,
        TERM_I,
        TERM_D
    } t_term;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ERR,
        OP_DIFF,
        OP_MLO,
        OP_MHI,
        OP_INTEG,
        OP_DERIV,
        OP_TERM,
        OP_OUT,
        OP_PUSH
    } t_op;

    typedef struct packed {
        t_op   op;
        t_term term;
        logic  inner;
    } t_cmd;

endpackage

[hw/rtl/cpid_in_if.sv]
// ----------------------------------------------------------------------------
// cpid_in_if
// Input channel: angle setpoint, measured angle and measured rate.
// ----------------------------------------------------------------------------
interface cpid_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] angle_setpoint;
    logic signed [DATA_WIDTH-1:0] angle_measured;
    logic signed [DATA_WIDTH-1:0] rate_measured;

    modport source (output valid, angle_setpoint, angle_measured, rate_measured,
                    input ready);
    modport sink   (input valid, angle_setpoint, angle_measured, rate_measured,
                    output ready);
endinterface

[hw/rtl/cpid_out_if.sv]
// ----------------------------------------------------------------------------
// cpid_out_if
// Result channel: drive value and rate setpoint.
// ----------------------------------------------------------------------------
interface cpid_out_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] drive_value;
    logic signed [DATA_WIDTH-1:0] rate_setpoint;

    modport source (output valid, drive_value, rate_setpoint, input ready);
    modport sink   (input valid, drive_value, rate_setpoint, output ready);
endinterface

[hw/rtl/cascaded_pid_controller_top.sv]
// ----------------------------------------------------------------------------
// cascaded_pid_controller_top
// Cascaded angle/rate PID controller in fixed point.
// ----------------------------------------------------------------------------
// Each item is loaded, then worked through both loops in turn (error,
// difference, five multiplies of a low and a high partial product plus a
// post step each, output saturation), then moved into the output register.
// The single shared 20x25 multiplier forms every product as two partial
// products. The input is taken only when the sequencer is idle; a finished
// result waits in the output register while the next item is worked on.
module cascaded_pid_controller_top import cpid_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    cpid_in_if.sink              i_in,
    cpid_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cmd cmd;

    cpid_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_out_ready(o_out.ready),
        .o_out_valid(o_out.valid),
        .o_cmd      (cmd)
    );

    cpid_dp #(
        .DATA_WIDTH(DATA_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_angle_setpoint(i_in.angle_setpoint),
        .i_angle_measured(i_in.angle_measured),
        .i_rate_measured (i_in.rate_measured),
        .o_drive_value   (o_out.drive_value),
        .o_rate_setpoint (o_out.rate_setpoint)
    );

    // a result cannot appear the cycle after a transfer in
    a_no_fast_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !$rose(o_out.valid))
        else $error("result appeared right after input transfer");

    // results are pushed only while an item is in flight
    a_push_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(!i_in.ready))
        else $error("result pushed while idle");

    // the sequencer issues commands only while busy or on a transfer
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.ready && !i_in.valid) |-> (cmd.op == OP_NONE))
        else $error("command issued while idle");

endmodule

[hw/rtl/cpid_ctrl.sv]
// ----------------------------------------------------------------------------
// cpid_ctrl
// Sequencer: walks both loops through error, difference, five multiplies
// and output saturation, then hands the result to the output register.
// ----------------------------------------------------------------------------
module cpid_ctrl import cpid_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    t_term  r_term,  n_term;
    logic   r_inner, n_inner;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_term      <= TERM_STEP;
            r_inner     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_term      <= n_term;
            r_inner     <= n_inner;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state     = r_state;
        n_term      = r_term;
        n_inner     = r_inner;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_ERR;
                    n_inner = 1'b0;
                end
            end
            S_ERR:  n_state = S_DIFF;
            S_DIFF: begin
                n_state = S_MLO;
                n_term  = TERM_STEP;
            end
            S_MLO:  n_state = S_MHI;
            S_MHI:  n_state = S_POST;
            S_POST: begin
                if (r_term == TERM_D) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_MLO;
                    n_term  = t_term'(r_term + 3'd1);
                end
            end
            S_OUT: begin
                if (r_inner) begin
                    n_state = S_PUSH;
                end else begin
                    n_state = S_ERR;
                    n_inner = 1'b1;
                end
            end
            S_PUSH: begin
                // hold until the output register can take the result
                if (slot_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd.op    = OP_NONE;
        o_cmd.term  = r_term;
        o_cmd.inner = r_inner;
        case (r_state)
            S_IDLE: if (i_in_valid) begin
                o_cmd.op = OP_LOAD;
            end
            S_ERR:  o_cmd.op = OP_ERR;
            S_DIFF: o_cmd.op = OP_DIFF;
            S_MLO:  o_cmd.op = OP_MLO;
            S_MHI:  o_cmd.op = OP_MHI;
            S_POST: begin
                case (r_term)
                    TERM_STEP:  o_cmd.op = OP_INTEG;
                    TERM_DERIV: o_cmd.op = OP_DERIV;
                    default:    o_cmd.op = OP_TERM;
                endcase
            end
            S_OUT:  o_cmd.op = OP_OUT;
            S_PUSH: if (slot_free) begin
                o_cmd.op = OP_PUSH;
            end
            default: o_cmd.op = OP_NONE;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[hw/rtl/cpid_dp.sv]
// ----------------------------------------------------------------------------
// cpid_dp
// Datapath: gain registers, loop state, one shared 20x25 multiplier used
// as two partial products per operation, the accumulator and saturation.
// ----------------------------------------------------------------------------
module cpid_dp import cpid_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_W-1:0]             i_cfg_data,
    input  logic signed [DATA_WIDTH-1:0] i_angle_setpoint,
    input  logic signed [DATA_WIDTH-1:0] i_angle_measured,
    input  logic signed [DATA_WIDTH-1:0] i_rate_measured,
    output logic signed [DATA_WIDTH-1:0] o_drive_value,
    output logic signed [DATA_WIDTH-1:0] o_rate_setpoint
);

    localparam int DW  = DATA_WIDTH;
    localparam int EXT = MAG_W + 1;
    localparam int IW  = PROD_W + 1;

    localparam logic signed [DW:0] ERR_HI = (DW+1)'((64'sd1 <<< (DW - 1)) - 64'sd1);
    localparam logic signed [DW:0] ERR_LO = -ERR_HI - (DW+1)'(1);
    localparam logic signed [IW-1:0] INT_HI = IW'((64'sd1 <<< (INTEG_W - 1)) - 64'sd1);
    localparam logic signed [IW-1:0] INT_LO = -INT_HI - IW'(1);
    localparam logic [PROD_W-1:0] DLIM = PROD_W'(1) << (INTEG_W - 1);
    localparam logic signed [SUM_W-1:0] OUT_HI = (SUM_W'(1) <<< (DW - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] OUT_LO = -OUT_HI - SUM_W'(1);

    logic [GAIN_W-1:0]   r_okp, r_oki, r_okd, r_ikp, r_iki, r_ikd;
    logic [PERIOD_W-1:0] r_period, r_inv;

    logic signed [DW-1:0]      r_asp, r_ams, r_rms;
    logic signed [DW-1:0]      r_err;
    logic signed [DW:0]        r_diff;
    logic signed [INTEG_W-1:0] r_integ [2];
    logic signed [DW-1:0]      r_last  [2];
    logic signed [INTEG_W-1:0] r_deriv;
    logic [PROD_W-1:0]         r_acc, r_prod;
    logic                      r_msign;
    logic signed [SUM_W-1:0]   r_sum;
    logic signed [DW-1:0]      r_rate_sp, r_drive;
    logic signed [DW-1:0]      r_o_drive, r_o_rate;

    logic [GAIN_W-1:0]        a_op;
    logic signed [EXT-1:0]    b_val;
    logic                     b_neg;
    logic [MAG_W-1:0]         b_mag;
    logic [HI_W-1:0]          b_part;
    logic [GAIN_W+HI_W-1:0]   mul_out;
    logic signed [DW-1:0]     sp, ms;
    logic signed [DW:0]       err_wide;
    logic signed [IW-1:0]     step_s, integ_sum;
    logic [PROD_W-1:0]        step_mag, term_mag;
    logic signed [SUM_W-1:0]  term_s;
    logic signed [SUM_W-1:0]  sum_sat;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_okp    <= OUTER_KP_RST;
            r_oki    <= '0;
            r_okd    <= '0;
            r_ikp    <= INNER_KP_RST;
            r_iki    <= '0;
            r_ikd    <= '0;
            r_period <= PERIOD_RST;
            r_inv    <= INV_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_OUTER_KP: r_okp    <= i_cfg_data;
                REG_OUTER_KI: r_oki    <= i_cfg_data;
                REG_OUTER_KD: r_okd    <= i_cfg_data;
                REG_INNER_KP: r_ikp    <= i_cfg_data;
                REG_INNER_KI: r_iki    <= i_cfg_data;
                REG_INNER_KD: r_ikd    <= i_cfg_data;
                REG_PERIOD:   r_period <= i_cfg_data[PERIOD_W-1:0];
                REG_INV:      r_inv    <= i_cfg_data[PERIOD_W-1:0];
                default:      r_inv    <= r_inv;
            endcase
        end
    end

    // multiplier operands
    always_comb begin
        case (i_cmd.term)
            TERM_STEP: begin
                a_op  = GAIN_W'(r_period);
                b_val = EXT'(r_err);
            end
            TERM_DERIV: begin
                a_op  = GAIN_W'(r_inv);
                b_val = EXT'(r_diff);
            end
            TERM_P: begin
                a_op  = i_cmd.inner ? r_ikp : r_okp;
                b_val = EXT'(r_err);
            end
            TERM_I: begin
                a_op  = i_cmd.inner ? r_iki : r_oki;
                b_val = EXT'(r_integ[i_cmd.inner]);
            end
            TERM_D: begin
                a_op  = i_cmd.inner ? r_ikd : r_okd;
                b_val = EXT'(r_deriv);
            end
            default: begin
                a_op  = '0;
                b_val = '0;
            end
        endcase
        b_neg = b_val[EXT-1];
        b_mag = b_neg ? MAG_W'(-b_val) : MAG_W'(b_val);
    end

    // low half of the magnitude first, high half on the following cycle
    assign b_part  = (i_cmd.op == OP_MHI) ? b_mag[MAG_W-1:LO_W] : HI_W'(b_mag[LO_W-1:0]);
    assign mul_out = a_op * b_part;

    assign sp       = i_cmd.inner ? r_rate_sp : r_asp;
    assign ms       = i_cmd.inner ? r_rms : r_ams;
    assign err_wide = (DW+1)'(sp) - (DW+1)'(ms);

    assign step_mag  = r_prod >> PERIOD_W;
    assign step_s    = r_msign ? -IW'(step_mag) : IW'(step_mag);
    assign integ_sum = IW'(r_integ[i_cmd.inner]) + step_s;

    assign term_mag = r_prod >> FRAC_BITS;
    assign term_s   = r_msign ? -SUM_W'(term_mag[SUM_W-2:0])
                              :  SUM_W'(term_mag[SUM_W-2:0]);

    assign sum_sat = (r_sum > OUT_HI) ? OUT_HI : ((r_sum < OUT_LO) ? OUT_LO : r_sum);

    // loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ[0] <= '0;
            r_integ[1] <= '0;
            r_last[0]  <= '0;
            r_last[1]  <= '0;
        end else begin
            case (i_cmd.op)
                OP_DIFF: r_last[i_cmd.inner] <= r_err;
                OP_INTEG: begin
                    if (integ_sum > INT_HI) begin
                        r_integ[i_cmd.inner] <= INTEG_W'(INT_HI);
                    end else if (integ_sum < INT_LO) begin
                        r_integ[i_cmd.inner] <= INTEG_W'(INT_LO);
                    end else begin
                        r_integ[i_cmd.inner] <= INTEG_W'(integ_sum);
                    end
                end
                default: r_integ[0] <= r_integ[0];
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_asp <= i_angle_setpoint;
                r_ams <= i_angle_measured;
                r_rms <= i_rate_measured;
            end
            OP_ERR: begin
                r_sum <= '0;
                if (err_wide > ERR_HI) begin
                    r_err <= DW'(ERR_HI);
                end else if (err_wide < ERR_LO) begin
                    r_err <= DW'(ERR_LO);
                end else begin
                    r_err <= DW'(err_wide);
                end
            end
            OP_DIFF: r_diff <= (DW+1)'(r_err) - (DW+1)'(r_last[i_cmd.inner]);
            OP_MLO: begin
                r_acc   <= PROD_W'(mul_out);
                r_msign <= b_neg;
            end
            OP_MHI: r_prod <= r_acc + (PROD_W'(mul_out) << LO_W);
            OP_DERIV: begin
                if (r_prod >= DLIM) begin
                    r_deriv <= r_msign ? -INTEG_W'(DLIM) : INTEG_W'(DLIM - PROD_W'(1));
                end else begin
                    r_deriv <= r_msign ? -INTEG_W'(r_prod) : INTEG_W'(r_prod);
                end
            end
            OP_TERM: r_sum <= r_sum + term_s;
            OP_OUT: begin
                if (i_cmd.inner) begin
                    r_drive <= DW'(sum_sat);
                end else begin
                    r_rate_sp <= DW'(sum_sat);
                end
            end
            OP_PUSH: begin
                r_o_drive <= r_drive;
                r_o_rate  <= r_rate_sp;
            end
            default: r_acc <= r_acc;
        endcase
    end

    assign o_drive_value   = r_o_drive;
    assign o_rate_setpoint = r_o_rate;

endmodule

[tb/sv/cascaded_pid_controller_top_tb.sv]
// ----------------------------------------------------------------------------
// cascaded_pid_controller_top_tb
// Self-checking bench for the cascaded angle/rate PID controller: random and
// directed ticks, gain and period settings changed between phases, results
// compared field by field against an in-bench fixed-point loop predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cascaded_pid_controller_top_tb;
    import cpid_pkg::*;

    localparam int DW       = 32;
    localparam int FB       = 16;
    localparam int SETTLE   = 60;

    typedef struct packed {
        logic signed [DW-1:0] angle_sp;
        logic signed [DW-1:0] angle_ms;
        logic signed [DW-1:0] rate_ms;
    } t_tick;

    typedef struct packed {
        logic signed [DW-1:0] drive;
        logic signed [DW-1:0] rate_sp;
    } t_ctrl;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    cpid_in_if  #(.DATA_WIDTH(DW)) in_ch ();
    cpid_out_if #(.DATA_WIDTH(DW)) out_ch ();

    cascaded_pid_controller_top #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // predictor state
    logic [GAIN_W-1:0]   gain [6];
    logic [PERIOD_W-1:0] period_q, inv_q;
    longint              integ_q [2];
    longint              last_err_q [2];

    t_tick  tick_q [$];
    t_ctrl  ctrl_q [$];
    int     fail_cnt = 0;
    int     sent_cnt = 0;
    int     recv_cnt = 0;
    bit     hold_off = 1'b0;
    bit     calm = 1'b0;

    initial forever #2 i_clk = ~i_clk;

    function automatic longint sat(longint v, int w);
        longint hi, lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : (v < lo) ? lo : v;
    endfunction

    // exact product, then truncate toward zero
    function automatic longint mul_trunc(longint g, longint v, int sh);
        logic [127:0] mag, prod;
        mag  = (v < 0) ? 128'(-v) : 128'(v);
        prod = (128'(g) * mag) >> sh;
        return (v < 0) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    function automatic longint pid_loop(int k, longint sp, longint ms);
        longint err, diff, deriv, sum;
        logic [127:0] dmag;
        err = sat(sp - ms, DW);
        integ_q[k] = sat(integ_q[k] + mul_trunc(period_q, err, 16), INTEG_W);
        diff = err - last_err_q[k];
        dmag = ((diff < 0) ? 128'(-diff) : 128'(diff)) * inv_q;
        if (dmag >= (128'(1) << (INTEG_W - 1)))
            deriv = (diff < 0) ? -(longint'(1) <<< (INTEG_W - 1))
                               : (longint'(1) <<< (INTEG_W - 1)) - 1;
        else
            deriv = (diff < 0) ? -longint'(dmag[63:0]) : longint'(dmag[63:0]);
        sum = mul_trunc(gain[3*k], err, FB) + mul_trunc(gain[3*k+1], integ_q[k], FB)
            + mul_trunc(gain[3*k+2], deriv, FB);
        last_err_q[k] = err;
        return sat(sum, DW);
    endfunction

    function automatic t_ctrl predict_ctrl(t_tick t);
        t_ctrl r;
        longint rsp, drv;
        rsp = pid_loop(0, t.angle_sp, t.angle_ms);
        r.rate_sp = rsp[DW-1:0];
        drv = pid_loop(1, rsp, t.rate_ms);
        r.drive   = drv[DW-1:0];
        return r;
    endfunction

    task automatic write_reg(t_reg_idx idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_PERIOD: period_q = val[PERIOD_W-1:0];
            REG_INV:    inv_q = val[PERIOD_W-1:0];
            default:    gain[int'(idx)] = val[GAIN_W-1:0];
        endcase
    endtask

    task automatic drain();
        wait (tick_q.size() == 0 && sent_cnt == recv_cnt);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [DW-1:0] rand_val(int mode);
        case (mode)
            0: return $urandom;
            1: return DW'($signed($urandom_range(0, 131072)) - 65536);
            2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return DW'($signed($urandom_range(0, 2000000)) - 1000000);
        endcase
    endfunction

    task automatic push_tick(logic [DW-1:0] a, logic [DW-1:0] b, logic [DW-1:0] c);
        t_tick t;
        t.angle_sp = a;
        t.angle_ms = b;
        t.rate_ms  = c;
        tick_q.push_back(t);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                ctrl_q.push_back(predict_ctrl({in_ch.angle_setpoint, in_ch.angle_measured,
                                               in_ch.rate_measured}));
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (tick_q.size() != 0 && !hold_off
                        && (calm || $urandom_range(0, 99) >= 37)) begin
                    t_tick t;
                    t = tick_q.pop_front();
                    in_ch.valid          <= 1'b1;
                    in_ch.angle_setpoint <= t.angle_sp;
                    in_ch.angle_measured <= t.angle_ms;
                    in_ch.rate_measured  <= t.rate_ms;
                    sent_cnt <= sent_cnt + 1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                recv_cnt <= recv_cnt + 1;
                if (ctrl_q.size() == 0) begin
                    $error("unexpected result: drive_value %0d rate_setpoint %0d",
                           out_ch.drive_value, out_ch.rate_setpoint);
                    fail_cnt++;
                end else begin
                    t_ctrl e;
                    e = ctrl_q.pop_front();
                    if (out_ch.drive_value !== e.drive) begin
                        $error("drive_value expected %0d actual %0d",
                               e.drive, out_ch.drive_value);
                        fail_cnt++;
                    end
                    if (out_ch.rate_setpoint !== e.rate_sp) begin
                        $error("rate_setpoint expected %0d actual %0d",
                               e.rate_sp, out_ch.rate_setpoint);
                        fail_cnt++;
                    end
                end
            end
            out_ch.ready <= calm || ($urandom_range(0, 99) >= 37);
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.angle_setpoint = '0;
        in_ch.angle_measured = '0;
        in_ch.rate_measured = '0;
        out_ch.ready = 1'b0;
        gain = '{OUTER_KP_RST, 0, 0, INNER_KP_RST, 0, 0};
        period_q = PERIOD_RST;
        inv_q = INV_RST;
        integ_q = '{0, 0};
        last_err_q = '{0, 0};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset gains, extremes and saturating differences
        push_tick(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
        push_tick(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        push_tick(0, 0, 0);
        push_tick(32'h0001_0000, 32'hffff_0000, 32'h0000_8000);
        push_tick(32'hffff_ffff, 32'h0000_0001, 32'h7fff_ffff);
        drain();
        write_reg(REG_OUTER_KP, 20'hfffff);
        write_reg(REG_OUTER_KI, 20'hfffff);
        write_reg(REG_OUTER_KD, 20'hfffff);
        write_reg(REG_INNER_KP, 20'hfffff);
        write_reg(REG_INNER_KI, 20'hfffff);
        write_reg(REG_INNER_KD, 20'hfffff);
        write_reg(REG_PERIOD, 20'h0ffff);
        write_reg(REG_INV, 20'h0ffff);
        for (int i = 0; i < 8; i++)
            push_tick(rand_val(2), rand_val(2), rand_val(2));
        push_tick(32'h1234_5678, 32'h8765_4321, 32'hdead_beef);
        drain();
        // zero periods freeze integrators and clear derivative
        write_reg(REG_PERIOD, '0);
        write_reg(REG_INV, '0);
        write_reg(REG_OUTER_KP, '0);
        for (int i = 0; i < 6; i++)
            push_tick(rand_val(0), rand_val(0), rand_val(0));

        // random phases with varied settings
        for (int ph = 0; ph < 12; ph++) begin
            drain();
            calm = (ph == 4);
            for (int r = 0; r < 6; r++)
                write_reg(t_reg_idx'(r), (ph % 3 == 0) ? CFG_W'($urandom)
                                         : CFG_W'($urandom_range(0, 131072)));
            write_reg(REG_PERIOD, CFG_W'((ph == 7) ? 1 : $urandom_range(1, 65535)));
            write_reg(REG_INV, CFG_W'((ph == 8) ? 65535 : $urandom_range(1, 4000)));
            for (int i = 0; i < 150; i++) begin
                int m;
                m = (i % 17 == 0) ? 2 : $urandom_range(0, 3);
                push_tick(rand_val(m), rand_val(m), rand_val(m));
                if (ph == 5 && i == 75) begin
                    // let traffic run, then hold the sender until all results are back
                    wait (tick_q.size() <= 40);
                    hold_off = 1'b1;
                    wait (sent_cnt == recv_cnt);
                    repeat (SETTLE) @(posedge i_clk);
                    hold_off = 1'b0;
                end
            end
        end
        drain();
        $display("Ran %0d control ticks over 15 gain/period settings,", recv_cnt);
        $display("including extremes, zero periods and saturating inputs.");
        if (fail_cnt == 0 && ctrl_q.size() == 0)
            $display("*** PASSED ***");
        else begin
            if (ctrl_q.size() != 0)
                $error("%0d expected results never arrived", ctrl_q.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule

[sim.f]
hw/rtl/cpid_pkg.sv
hw/rtl/cpid_in_if.sv
hw/rtl/cpid_out_if.sv
hw/rtl/cpid_ctrl.sv
hw/rtl/cpid_dp.sv
hw/rtl/cascaded_pid_controller_top.sv
tb/sv/cascaded_pid_controller_top_tb.sv
